[rtl/bra_pkg.sv]
// shared types and constants of the bounded rational approximation block
package bra_pkg;

    // limit used when a limit field is zero
    localparam int DEFAULT_LIMIT      = 32'h1000_0000;
    localparam int DEFAULT_LIMIT_BITS = 29;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_UPDATE,
        S_FINISH
    } t_state;

    // per-step status from the shared divide/accumulate unit
    typedef struct packed {
        logic qbit;
        logic p_over;
        logic q_over;
    } t_step_flags;

endpackage

[rtl/bra_step_unit.sv]
// shared divide / shift-accumulate step: one quotient bit and two partial products per cycle
module bra_step_unit
    import bra_pkg::*;
#(
    parameter int W  = 32,
    parameter int LW = 31
) (
    input  logic [W-1:0]  i_rem,
    input  logic          i_dividend_msb,
    input  logic [W-1:0]  i_divisor,
    input  logic [LW-1:0] i_acc_p,
    input  logic [LW-1:0] i_acc_q,
    input  logic [LW-1:0] i_p1,
    input  logic [LW-1:0] i_q1,
    input  logic [LW-1:0] i_nlim,
    input  logic [LW-1:0] i_dlim,
    input  t_step_flags   i_flags,
    output logic [W-1:0]  o_rem,
    output logic [LW-1:0] o_acc_p,
    output logic [LW-1:0] o_acc_q,
    output t_step_flags   o_flags
);

    logic [W+1:0]  trial;
    logic [W:0]    shifted;
    logic          qbit;
    logic [LW+1:0] sum_p;
    logic [LW+1:0] sum_q;

    always_comb begin
        // restoring division step
        shifted = {i_rem, i_dividend_msb};
        trial   = {1'b0, shifted} - {2'b00, i_divisor};
        qbit    = ~trial[W+1];
        o_rem   = qbit ? trial[W-1:0] : shifted[W-1:0];

        // quotient bits arrive msb first, so acc = 2*acc + bit*prev
        sum_p = {1'b0, i_acc_p, 1'b0} + (qbit ? {2'b00, i_p1} : '0);
        sum_q = {1'b0, i_acc_q, 1'b0} + (qbit ? {2'b00, i_q1} : '0);

        // once over the limit the product stays over, keep it sticky
        o_flags.qbit   = qbit;
        o_flags.p_over = i_flags.p_over || (sum_p > {2'b00, i_nlim});
        o_flags.q_over = i_flags.q_over || (sum_q > {2'b00, i_dlim});
        o_acc_p        = sum_p[LW-1:0];
        o_acc_q        = sum_q[LW-1:0];
    end

endmodule

[rtl/bounded_rational_approximation.sv]
// top level: sequencer and registers of the bounded rational approximation block
//
// usage
// - input channel i_in_valid / o_in_ready carries one request: a signed
//   fraction (numerator, denominator) and two limits, a zero limit meaning
//   0x10000000
// - output channel o_out_valid / i_out_ready returns one result per request:
//   the last continued-fraction convergent whose numerator and denominator
//   stay within the limits, signed by the xor of the input signs; 1/0 for a
//   zero denominator or an immediate overflow; 0/0 with o_undefined_input
//   set when both inputs are zero
// - one request at a time: o_in_ready is high only while the sequencer idles
// - each continued-fraction term runs on the shared step unit as DATA_WIDTH
//   restoring divide steps, each also folding one quotient bit into both
//   convergent products, followed by the update state
// - at 32 bits a request has at most about 46 terms
// - the result sits in an output register; a new request is accepted while
//   it waits, and a finished search holds until that register is free
// - synchronous active-low reset empties the output register and idles
//   the sequencer
module bounded_rational_approximation
    import bra_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_numerator_in,
    input  logic signed [DATA_WIDTH-1:0] i_denominator_in,
    input  logic        [DATA_WIDTH-2:0] i_numerator_limit,
    input  logic        [DATA_WIDTH-2:0] i_denominator_limit,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_numerator_out,
    output logic        [DATA_WIDTH-2:0] o_denominator_out,
    output logic                         o_undefined_input
);

    localparam int W  = DATA_WIDTH;
    // limits and convergents need room for the default limit too
    localparam int LW = (W - 1 > DEFAULT_LIMIT_BITS) ? W - 1 : DEFAULT_LIMIT_BITS;
    localparam int CW = $clog2(W);

    // control
    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_cnt, n_cnt;

    // datapath
    logic [W-1:0]  r_dq, n_dq;     // dividend, quotient bits shift in at the bottom
    logic [W-1:0]  r_y, n_y;       // divisor
    logic [W-1:0]  r_rem, n_rem;   // partial remainder
    logic [LW-1:0] r_acc_p, n_acc_p;
    logic [LW-1:0] r_acc_q, n_acc_q;
    logic          r_p_over, n_p_over;
    logic          r_q_over, n_q_over;
    logic [LW-1:0] r_p1, n_p1, r_p2, n_p2;
    logic [LW-1:0] r_q1, n_q1, r_q2, n_q2;
    logic [LW-1:0] r_nlim, n_nlim;
    logic [LW-1:0] r_dlim, n_dlim;
    logic          r_neg, n_neg;
    logic          r_undef, n_undef;
    logic [W-1:0]  r_num_out, n_num_out;
    logic [W-2:0]  r_den_out, n_den_out;
    logic          r_undef_out, n_undef_out;

    // step unit hookup
    logic [W-1:0]  step_rem;
    logic [LW-1:0] step_acc_p;
    logic [LW-1:0] step_acc_q;
    t_step_flags   step_in_flags;
    t_step_flags   step_flags;

    // input magnitudes and limits
    logic [W-1:0]  num_raw, den_raw;
    logic [W-1:0]  num_mag, den_mag;
    logic [LW-1:0] nlim_in, dlim_in;

    // update cycle
    logic [LW:0]   pn, qn;
    logic          too_big;
    logic [LW:0]   p_ext, p_sgn;
    logic          load_out;

    assign step_in_flags = '{qbit: 1'b0, p_over: r_p_over, q_over: r_q_over};

    bra_step_unit #(
        .W  (W),
        .LW (LW)
    ) u_step (
        .i_rem          (r_rem),
        .i_dividend_msb (r_dq[W-1]),
        .i_divisor      (r_y),
        .i_acc_p        (r_acc_p),
        .i_acc_q        (r_acc_q),
        .i_p1           (r_p1),
        .i_q1           (r_q1),
        .i_nlim         (r_nlim),
        .i_dlim         (r_dlim),
        .i_flags        (step_in_flags),
        .o_rem          (step_rem),
        .o_acc_p        (step_acc_p),
        .o_acc_q        (step_acc_q),
        .o_flags        (step_flags)
    );

    always_comb begin
        num_raw = i_numerator_in;
        den_raw = i_denominator_in;
        // most negative value maps to 2^(W-1), exact in W unsigned bits
        num_mag = num_raw[W-1] ? W'(~num_raw + 1'b1) : num_raw;
        den_mag = den_raw[W-1] ? W'(~den_raw + 1'b1) : den_raw;
        nlim_in = (i_numerator_limit == '0) ? LW'(DEFAULT_LIMIT) : LW'(i_numerator_limit);
        dlim_in = (i_denominator_limit == '0) ? LW'(DEFAULT_LIMIT) : LW'(i_denominator_limit);

        // next convergent from the accumulated products
        pn      = {1'b0, r_acc_p} + {1'b0, r_p2};
        qn      = {1'b0, r_acc_q} + {1'b0, r_q2};
        too_big = r_p_over || r_q_over || (pn > {1'b0, r_nlim}) || (qn > {1'b0, r_dlim});

        p_ext   = {1'b0, r_p1};
        p_sgn   = r_neg ? (~p_ext + 1'b1) : p_ext;
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_dq        = r_dq;
        n_y         = r_y;
        n_rem       = r_rem;
        n_acc_p     = r_acc_p;
        n_acc_q     = r_acc_q;
        n_p_over    = r_p_over;
        n_q_over    = r_q_over;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_q1        = r_q1;
        n_q2        = r_q2;
        n_nlim      = r_nlim;
        n_dlim      = r_dlim;
        n_neg       = r_neg;
        n_undef     = r_undef;
        n_num_out   = r_num_out;
        n_den_out   = r_den_out;
        n_undef_out = r_undef_out;
        load_out    = 1'b0;
        o_in_ready  = 1'b0;

        // output register drains independently of the search
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_nlim   = nlim_in;
                    n_dlim   = dlim_in;
                    n_neg    = num_raw[W-1] ^ den_raw[W-1];
                    n_undef  = (num_mag == '0) && (den_mag == '0);
                    // both zero yields 0/0 through p1 = 0
                    n_p1     = n_undef ? '0 : LW'(1);
                    n_p2     = '0;
                    n_q1     = '0;
                    n_q2     = LW'(1);
                    n_dq     = num_mag;
                    n_y      = den_mag;
                    n_rem    = '0;
                    n_acc_p  = '0;
                    n_acc_q  = '0;
                    n_p_over = 1'b0;
                    n_q_over = 1'b0;
                    n_cnt    = CW'(W - 1);
                    n_state  = (den_mag == '0) ? S_FINISH : S_DIV;
                end
            end

            S_DIV: begin
                n_rem    = step_rem;
                n_dq     = {r_dq[W-2:0], step_flags.qbit};
                n_acc_p  = step_acc_p;
                n_acc_q  = step_acc_q;
                n_p_over = step_flags.p_over;
                n_q_over = step_flags.q_over;
                if (r_cnt == '0) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end

            S_UPDATE: begin
                if (too_big) begin
                    n_state = S_FINISH;
                end else begin
                    n_p2 = r_p1;
                    n_p1 = pn[LW-1:0];
                    n_q2 = r_q1;
                    n_q1 = qn[LW-1:0];
                    // next term: x <- y, y <- remainder
                    n_dq     = r_y;
                    n_y      = r_rem;
                    n_rem    = '0;
                    n_acc_p  = '0;
                    n_acc_q  = '0;
                    n_p_over = 1'b0;
                    n_q_over = 1'b0;
                    n_cnt    = CW'(W - 1);
                    n_state  = (r_rem == '0) ? S_FINISH : S_DIV;
                end
            end

            S_FINISH: begin
                // wait for a free output register
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_num_out   = p_sgn[W-1:0];
                    n_den_out   = r_q1[W-2:0];
                    n_undef_out = r_undef;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_dq        <= n_dq;
        r_y         <= n_y;
        r_rem       <= n_rem;
        r_acc_p     <= n_acc_p;
        r_acc_q     <= n_acc_q;
        r_p_over    <= n_p_over;
        r_q_over    <= n_q_over;
        r_p1        <= n_p1;
        r_p2        <= n_p2;
        r_q1        <= n_q1;
        r_q2        <= n_q2;
        r_nlim      <= n_nlim;
        r_dlim      <= n_dlim;
        r_neg       <= n_neg;
        r_undef     <= n_undef;
        if (load_out) begin
            r_num_out   <= n_num_out;
            r_den_out   <= n_den_out;
            r_undef_out <= n_undef_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_numerator_out   = r_num_out;
    assign o_denominator_out = r_den_out;
    assign o_undefined_input = r_undef_out;

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_y != '0)
        else $error("divide step with zero divisor");

    // partial remainder stays below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_y)
        else $error("partial remainder not below divisor");

    // kept convergent is always within both limits
    a_kept_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_UPDATE) |-> (r_p1 <= r_nlim && r_q1 <= r_dlim))
        else $error("kept convergent exceeds a limit");

    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accepting a request");

    // undefined result carries a zero fraction
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_undefined_input |-> (o_numerator_out == '0 && o_denominator_out == '0))
        else $error("undefined result with nonzero fraction");

endmodule

[sim/tb.sv]
// self-checking testbench of the bounded rational approximation block
`timescale 1ns / 100ps

// one expected or observed result of the block
typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        undef;
} t_fraction;

// predicts the last in-limit convergent for each request and checks results in order
class approx_scoreboard;

    t_fraction pending_fractions[$];
    int        n_requests;
    int        n_results;
    int        n_mismatches;
    int        n_undefined;
    int        n_infinite;

    function new();
        n_requests   = 0;
        n_results    = 0;
        n_mismatches = 0;
        n_undefined  = 0;
        n_infinite   = 0;
    endfunction

    // magnitude of a 32-bit two's complement value, most negative included
    function bit [63:0] abs_wide(logic [31:0] v);
        bit [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return {32'd0, m};
    endfunction

    // true when term * cur + prev would go past lim
    function bit over_limit(bit [63:0] term, bit [63:0] cur, bit [63:0] prev,
                            bit [63:0] lim);
        if (cur == 0)
            return 1'b0;
        return term > (lim - prev) / cur;
    endfunction

    // last convergent of |num|/|den| that stays within both limits
    function t_fraction approximate(logic [31:0] num, logic [31:0] den,
                                    logic [30:0] nlim_f, logic [30:0] dlim_f);
        bit [63:0] x, y, nlim, dlim, term, rem;
        bit [63:0] p_prev, p_cur, q_prev, q_cur, p_next, q_next;
        bit        stop;
        t_fraction res;
        x    = abs_wide(num);
        y    = abs_wide(den);
        nlim = (nlim_f == 0) ? 64'(bra_pkg::DEFAULT_LIMIT) : 64'(nlim_f);
        dlim = (dlim_f == 0) ? 64'(bra_pkg::DEFAULT_LIMIT) : 64'(dlim_f);
        res  = '0;
        if (x == 0 && y == 0) begin
            res.undef = 1'b1;
            return res;
        end
        p_prev = 0;
        p_cur  = 1;
        q_prev = 1;
        q_cur  = 0;
        stop   = 1'b0;
        while (y != 0 && !stop) begin
            term = x / y;
            rem  = x - term * y;
            x    = y;
            y    = rem;
            if (over_limit(term, p_cur, p_prev, nlim) || over_limit(term, q_cur, q_prev, dlim)) begin
                stop = 1'b1;
            end else begin
                p_next = term * p_cur + p_prev;
                q_next = term * q_cur + q_prev;
                if (p_next > nlim || q_next > dlim) begin
                    stop = 1'b1;
                end else begin
                    p_prev = p_cur;
                    p_cur  = p_next;
                    q_prev = q_cur;
                    q_cur  = q_next;
                end
            end
        end
        res.num = (num[31] != den[31]) ? -p_cur[31:0] : p_cur[31:0];
        res.den = q_cur[30:0];
        return res;
    endfunction

    function void note_request(logic [31:0] num, logic [31:0] den,
                               logic [30:0] nlim, logic [30:0] dlim);
        t_fraction exp_f;
        exp_f = approximate(num, den, nlim, dlim);
        if (exp_f.undef)
            n_undefined++;
        else if (exp_f.den == 0)
            n_infinite++;
        pending_fractions.push_back(exp_f);
        n_requests++;
    endfunction

    function void check_result(logic [31:0] num, logic [30:0] den, logic undef);
        t_fraction exp_f;
        n_results++;
        if (pending_fractions.size() == 0) begin
            n_mismatches++;
            if (n_mismatches <= 10)
                $display("mismatch: result %0d/%0d undef %0b with no request pending",
                         $signed(num), den, undef);
            return;
        end
        exp_f = pending_fractions.pop_front();
        if (num !== exp_f.num || den !== exp_f.den || undef !== exp_f.undef) begin
            n_mismatches++;
            if (n_mismatches <= 10)
                $display("mismatch on result %0d: expected %0d/%0d undef %0b, got %0d/%0d undef %0b",
                         n_results, $signed(exp_f.num), exp_f.den, exp_f.undef,
                         $signed(num), den, undef);
        end
    endfunction

    function int pending();
        return pending_fractions.size();
    endfunction

endclass

module tb;

    // a search has at most about 46 terms
    localparam int LATENCY_TAIL = 1600;
    // run limit: every request at worst-case latency plus stalls, taken several times
    localparam int CYCLE_LIMIT  = 6_000_000;
    // length of the long receiver hold-off
    localparam int LONG_HOLD    = 4000;
    localparam int RANDOM_COUNT = 346;

    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [30:0] LIM_MAX  = 31'h7FFF_FFFF;

    logic        i_clk               = 1'b0;
    logic        i_rst_n             = 1'b0;
    logic        i_in_valid          = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_numerator_in      = '0;
    logic [31:0] i_denominator_in    = '0;
    logic [30:0] i_numerator_limit   = '0;
    logic [30:0] i_denominator_limit = '0;
    logic        o_out_valid;
    logic        i_out_ready         = 1'b0;
    logic [31:0] o_numerator_out;
    logic [30:0] o_denominator_out;
    logic        o_undefined_input;

    approx_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left  = 0;
    bit no_idle     = 1'b0;
    // long hold-off requests from the stimulus, served by the receiver
    int hold_asked  = 0;

    bounded_rational_approximation #(
        .DATA_WIDTH(32)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_numerator_in     (i_numerator_in),
        .i_denominator_in   (i_denominator_in),
        .i_numerator_limit  (i_numerator_limit),
        .i_denominator_limit(i_denominator_limit),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_numerator_out    (o_numerator_out),
        .o_denominator_out  (o_denominator_out),
        .o_undefined_input  (o_undefined_input)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung block ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // result monitor: every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_result(o_numerator_out, o_denominator_out, o_undefined_input);
    end

    // receiver: random stall modes, plus a long hold-off when asked
    int hold_served = 0;
    int hold_left   = 0;
    int stall_left  = 0;
    int rx_mode     = 0;
    int mode_left   = 0;

    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            // block fills up: one result held, one search stalled behind it
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(200, 3000);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (rx_mode == 0) begin
                // always ready
                i_out_ready <= 1'b1;
            end else if (rx_mode == 1) begin
                // short frequent stalls
                if ($urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 8);
                i_out_ready <= (stall_left == 0);
            end else begin
                // long rare stalls
                if ($urandom_range(0, 15) == 0)
                    stall_left = $urandom_range(10, 40);
                i_out_ready <= (stall_left == 0);
            end
        end
    end

    // sender pacing: bursts of back-to-back requests, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 8);
            no_idle    = ($urandom_range(0, 3) == 0);
            if (!no_idle) begin
                // mostly short gaps, some long enough to land after a result
                gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 25) : $urandom_range(0, 1500);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // present one request and hold it until the block takes it
    task automatic offer_request(logic [31:0] num, logic [31:0] den,
                                 logic [30:0] nlim, logic [30:0] dlim);
        i_in_valid          <= 1'b1;
        i_numerator_in      <= num;
        i_denominator_in    <= den;
        i_numerator_limit   <= nlim;
        i_denominator_limit <= dlim;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_request(num, den, nlim, dlim);
        pace_sender();
    endtask

    // stop sending until every pending result is back
    task automatic wait_for_drain();
        // with nothing pending the sender gap has already dropped valid
        if (sb.pending() != 0) begin
            i_in_valid <= 1'b0;
            while (sb.pending() != 0)
                @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_operand();
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(0, 19);
        if (sel < 10) begin
            v = $urandom();
        end else if (sel < 15) begin
            v = $urandom_range(1, 1000);
            if ($urandom_range(0, 1))
                v = -v;
        end else if (sel < 17) begin
            v = $urandom_range(1, 65535);
            if ($urandom_range(0, 1))
                v = -v;
        end else if (sel < 19) begin
            case ($urandom_range(0, 3))
                0:       v = MOST_NEG;
                1:       v = MOST_POS;
                2:       v = 32'd1;
                default: v = 32'hFFFF_FFFF;
            endcase
        end else begin
            v = '0;
        end
        return v;
    endfunction

    function automatic logic [30:0] rand_limit();
        int unsigned sel;
        logic [30:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            v = '0;
        else if (sel < 4)
            v = $urandom_range(1, 100);
        else if (sel < 6)
            v = $urandom_range(1, 65535);
        else if (sel < 9)
            v = $urandom();
        else
            v = LIM_MAX;
        return v;
    endfunction

    task automatic random_request();
        logic [31:0] num, den;
        logic [30:0] nlim, dlim;
        num  = rand_operand();
        den  = rand_operand();
        nlim = rand_limit();
        dlim = rand_limit();
        offer_request(num, den, nlim, dlim);
    endtask

    // stimulus
    initial begin
        int i;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both inputs zero
        offer_request(32'd0, 32'd0, 31'd0, 31'd0);
        offer_request(32'd0, 32'd0, LIM_MAX, LIM_MAX);
        // zero denominator, both signs
        offer_request(32'd5, 32'd0, 31'd0, 31'd0);
        offer_request(-32'sd5, 32'd0, 31'd0, 31'd0);
        // zero numerator
        offer_request(32'd0, 32'd7, 31'd0, 31'd0);
        offer_request(32'd0, -32'sd7, LIM_MAX, LIM_MAX);
        // most negative inputs
        offer_request(MOST_NEG, 32'd1, LIM_MAX, LIM_MAX);
        offer_request(MOST_NEG, MOST_NEG, LIM_MAX, LIM_MAX);
        offer_request(32'd1, MOST_NEG, LIM_MAX, LIM_MAX);
        offer_request(MOST_POS, MOST_NEG, LIM_MAX, LIM_MAX);
        // largest integer, within and over the default limit
        offer_request(MOST_POS, 32'd1, LIM_MAX, LIM_MAX);
        offer_request(MOST_POS, 32'd1, 31'd0, 31'd0);
        // first convergent already over a limit
        offer_request(32'd1000, 32'd1, 31'd10, 31'd0);
        offer_request(32'd7, 32'd3, 31'd1, 31'd1);
        // pi with small and mixed limits
        offer_request(32'd314159265, 32'd100000000, 31'd1000, 31'd1000);
        offer_request(-32'sd314159265, 32'd100000000, LIM_MAX, 31'd113);
        // golden ratio: the longest expansion
        offer_request(32'd1836311903, 32'd1134903170, LIM_MAX, LIM_MAX);
        offer_request(-32'sd1134903170, -32'sd1836311903, 31'd0, 31'd0);
        // unit magnitudes
        offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd1, 31'd1);
        offer_request(32'hFFFF_FFFF, 32'd1, 31'd0, 31'd0);
        // denominator limit stops after the integer part
        offer_request(32'd1, 32'd3, LIM_MAX, 31'd1);
        // exact fit on both limits
        offer_request(32'd22, 32'd7, 31'd22, 31'd7);
        // huge second term
        offer_request(MOST_POS, 32'h7FFF_FFFE, 31'd0, 31'd0);
        offer_request(32'd123456789, 32'd987654321, 31'd1, LIM_MAX);
        wait_for_drain();

        for (i = 0; i < RANDOM_COUNT; i++) begin
            if (i == 60 || i == 200 || i == 300)
                wait_for_drain();
            if (i == 120)
                hold_asked <= hold_asked + 1;
            random_request();
        end

        wait_for_drain();
        repeat (LATENCY_TAIL) @(posedge i_clk);

        $display("checked %0d results for %0d requests in %0d cycles",
                 sb.n_results, sb.n_requests, cycle_count);
        $display("%0d with both inputs zero, %0d giving an infinite quotient, %0d mismatches",
                 sb.n_undefined, sb.n_infinite, sb.n_mismatches);
        if (sb.n_mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
